// ----- design/pidc_pkg.sv -----
package pidc_pkg;

  // Widths of the sample path and of the Q-format gains
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned SETP_W      = 16;
  localparam int unsigned GAIN_W      = 32;
  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned DRIVE_W     = 16;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 3;

  // Error and delta carry one bit more than a sample
  localparam int unsigned ERR_W   = ((SAMPLE_BITS > SETP_W) ? SAMPLE_BITS : SETP_W) + 1;
  localparam int unsigned PROD_W  = ERR_W + GAIN_W;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned INTEG_W = 48;
  localparam int unsigned LIM_Q_W = LIMIT_W + FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT    = 3'd0,
    REG_KP_GAIN     = 3'd1,
    REG_KI_TIMES_DT = 3'd2,
    REG_KD_OVER_DT  = 3'd3,
    REG_MEAS_MODE   = 3'd4,
    REG_REVERSE_DIR = 3'd5,
    REG_OUT_MIN     = 3'd6,
    REG_OUT_MAX     = 3'd7
  } cfg_reg_e;

  localparam logic [LIMIT_W-1:0] OUT_MAX_RESET = LIMIT_W'(255);

  // Clamp a signed sum to [lo, hi]; below lo gives lo, anything else above hi gives hi
  function automatic logic signed [ACC_W-1:0] clamp_acc(
    input logic signed [ACC_W-1:0] x,
    input logic [LIM_Q_W-1:0]      lo,
    input logic [LIM_Q_W-1:0]      hi
  );
    logic signed [ACC_W-1:0] lo_s;
    logic signed [ACC_W-1:0] hi_s;
    logic signed [ACC_W-1:0] res;
    lo_s = $signed({{(ACC_W-LIM_Q_W){1'b0}}, lo});
    hi_s = $signed({{(ACC_W-LIM_Q_W){1'b0}}, hi});
    if (x < lo_s) begin
      res = lo_s;
    end else if (x > hi_s) begin
      res = hi_s;
    end else begin
      res = x;
    end
    return res;
  endfunction

endpackage

// ----- design/pid_regulator_clamped.sv -----
// PID regulator with derivative on measurement and a clamped integral.
// Configuration: write cfg_data_i to register cfg_index_i while cfg_wr_en_i
// is high; the register takes effect at once. Write only while no transaction
// is in flight. Registers: setpoint, kp, ki*dt, kd/dt (signed Q16.16), the
// measurement-mode and reverse-direction flags, and the out_min/out_max limits.
// Input channel: one sensor sample per transaction (in_valid_i/in_ready_o).
// Output channel: one drive value per sample (out_valid_o/out_ready_i).
// A sample passes the difference register, the multiplier register and the
// output register in turn. Throughput: one sample per cycle while the output
// is not stalled, set by the three-stage pipe (difference register, multiplier
// register, accumulate and clamp into the output register).
// Reset clears the previous sample and the integral, loads the register reset
// values (out_max = 255, all others zero) and empties the pipe.
// When the receiver stalls the result holds in the output register; the pipe
// keeps filling behind it and in_ready_o falls only once every stage is full.
module pid_regulator_clamped
  import pidc_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_wr_en_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sensor_sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [DRIVE_W-1:0]           drive_value_o
);

  // Configuration registers
  logic signed [SETP_W-1:0] setpoint_q;
  logic signed [GAIN_W-1:0] kp_gain_q;
  logic signed [GAIN_W-1:0] ki_times_dt_q;
  logic signed [GAIN_W-1:0] kd_over_dt_q;
  logic                     meas_mode_q;
  logic                     reverse_dir_q;
  logic [LIMIT_W-1:0]       out_min_q;
  logic [LIMIT_W-1:0]       out_max_q;

  // Pipe control
  logic v1_q, v2_q, out_valid_q;
  logic ld1, ld2, adv_out;

  // Stage 1: error and delta
  logic signed [SAMPLE_BITS-1:0] prev_sample_q;
  logic signed [ERR_W-1:0]       err_d, dlt_d, err1_q, dlt1_q;

  // Stage 2: products
  logic signed [ERR_W-1:0]  kp_op;
  logic signed [PROD_W-1:0] kp_prod_d, ki_prod_d, kd_prod_d;
  logic signed [PROD_W-1:0] kp_prod_q, ki_prod_q, kd_prod_q;

  // Stage 3: integral and output
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [ACC_W-1:0]   integ_raw, integ_d, sum_raw, sum_clamped;
  logic [LIM_Q_W-1:0]        lo_q16, hi_q16;
  logic [DRIVE_W-1:0]        drive_d, drive_q;

  // Write configuration, keeping only each register's width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q    <= '0;
      kp_gain_q     <= '0;
      ki_times_dt_q <= '0;
      kd_over_dt_q  <= '0;
      meas_mode_q   <= 1'b0;
      reverse_dir_q <= 1'b0;
      out_min_q     <= '0;
      out_max_q     <= OUT_MAX_RESET;
    end else if (cfg_wr_en_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_SETPOINT:    setpoint_q    <= cfg_data_i[SETP_W-1:0];
        REG_KP_GAIN:     kp_gain_q     <= cfg_data_i[GAIN_W-1:0];
        REG_KI_TIMES_DT: ki_times_dt_q <= cfg_data_i[GAIN_W-1:0];
        REG_KD_OVER_DT:  kd_over_dt_q  <= cfg_data_i[GAIN_W-1:0];
        REG_MEAS_MODE:   meas_mode_q   <= cfg_data_i[0];
        REG_REVERSE_DIR: reverse_dir_q <= cfg_data_i[0];
        REG_OUT_MIN:     out_min_q     <= cfg_data_i[LIMIT_W-1:0];
        REG_OUT_MAX:     out_max_q     <= cfg_data_i[LIMIT_W-1:0];
        default:         setpoint_q    <= setpoint_q;
      endcase
    end
  end

  // Advance each stage when the one after it can take its contents
  assign adv_out    = !out_valid_q || out_ready_i;
  assign ld2        = !v2_q || adv_out;
  assign ld1        = !v1_q || ld2;
  assign in_ready_o = ld1;

  // Form error and delta, negated for a reverse-acting plant
  always_comb begin
    err_d = ERR_W'(setpoint_q) - ERR_W'(sensor_sample_i);
    dlt_d = ERR_W'(prev_sample_q) - ERR_W'(sensor_sample_i);
    if (reverse_dir_q) begin
      err_d = -err_d;
      dlt_d = -dlt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q          <= 1'b0;
      prev_sample_q <= '0;
    end else if (ld1) begin
      v1_q <= in_valid_i;
      if (in_valid_i) begin
        prev_sample_q <= sensor_sample_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1 && in_valid_i) begin
      err1_q <= err_d;
      dlt1_q <= dlt_d;
    end
  end

  // Multiply; kp takes delta in measurement mode and error otherwise
  assign kp_op     = meas_mode_q ? dlt1_q : err1_q;
  assign kp_prod_d = kp_op * kp_gain_q;
  assign ki_prod_d = err1_q * ki_times_dt_q;
  assign kd_prod_d = dlt1_q * kd_over_dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (ld2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld2 && v1_q) begin
      kp_prod_q <= kp_prod_d;
      ki_prod_q <= ki_prod_d;
      kd_prod_q <= kd_prod_d;
    end
  end

  // Accumulate the integral (with P in measurement mode), clamp it, add D (and P otherwise) and clamp the sum
  assign lo_q16 = {out_min_q, {FRAC_BITS{1'b0}}};
  assign hi_q16 = {out_max_q, {FRAC_BITS{1'b0}}};

  always_comb begin
    integ_raw = ACC_W'(integ_q) + ACC_W'(ki_prod_q);
    if (meas_mode_q) begin
      integ_raw = integ_raw + ACC_W'(kp_prod_q);
    end
    integ_d = clamp_acc(integ_raw, lo_q16, hi_q16);
    sum_raw = integ_d + ACC_W'(kd_prod_q);
    if (!meas_mode_q) begin
      sum_raw = sum_raw + ACC_W'(kp_prod_q);
    end
    sum_clamped = clamp_acc(sum_raw, lo_q16, hi_q16);
    drive_d     = sum_clamped[FRAC_BITS +: DRIVE_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      integ_q     <= '0;
    end else if (adv_out) begin
      out_valid_q <= v2_q;
      if (v2_q) begin
        integ_q <= INTEG_W'(integ_d);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && v2_q) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_value_o = drive_q;

endmodule

// ----- design/pidc_checker.sv -----
module pidc_checker
  import pidc_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [DRIVE_W-1:0]            drive_value_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_value_o))
    else $error("stalled result changed or dropped");

  // A free output side never stops the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> in_ready_o)
    else $error("input stalled while output can drain");

  // A transaction reaches the output through every stage when the output side stays ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("result missing after pipe latency");

  // No result without an earlier transaction to feed it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 3))
    else $error("result appeared without a matching input");

endmodule

bind pid_regulator_clamped pidc_checker u_pidc_checker (.*);
